@@ hdl/time_of_day_schedule_trigger_assert.svh @@
// Assertion macros for the schedule trigger checker.
`ifndef TIME_OF_DAY_SCHEDULE_TRIGGER_ASSERT_SVH
`define TIME_OF_DAY_SCHEDULE_TRIGGER_ASSERT_SVH

// Check cons in the same cycle that ante holds.
`define TODS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante holds.
`define TODS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tods_pkg.sv @@
// Types, constants and codes shared by the schedule trigger files.
package tods_pkg;

    localparam int NUM_SCHEDULES_DEF = 16;
    localparam int MAX_EVENTS        = 16;
    localparam int SEC_W             = 17;
    localparam int FUNC_W            = 32;
    localparam int IDX_OUT_W         = 4;
    localparam int EVT_CNT_W         = $clog2(MAX_EVENTS + 1);
    localparam int REPEAT_BIT        = 7;

    localparam logic [FUNC_W-1:0] FUNC_NONE = '1;

    // Opcodes of the input transfer
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Event actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STOP  = 1'b1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [2:0]        day_of_week;
        logic [SEC_W-1:0]  second_of_day;
        logic [SEC_W-1:0]  entry_start;
        logic              entry_has_stop;
        logic [SEC_W-1:0]  entry_stop;
        logic [7:0]        entry_week_flags;
        logic [FUNC_W-1:0] entry_function;
    } t_in_item;

    typedef struct packed {
        logic                 action;
        logic [FUNC_W-1:0]    function_id;
        logic [IDX_OUT_W-1:0] entry_index;
        logic                 last;
    } t_out_item;

    // One stored schedule entry
    typedef struct packed {
        logic [SEC_W-1:0]  start;
        logic              has_stop;
        logic [SEC_W-1:0]  stop;
        logic [7:0]        week_flags;
        logic [FUNC_W-1:0] func;
    } t_entry;

    // Write controls toward the entry store
    typedef struct packed {
        logic entry_we;
        logic armed_we;
        logic armed_val;
    } t_store_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FLUSH
    } t_state;

endpackage

@@ hdl/tods_store.sv @@
// Schedule entry memory and armed-flag memory, one write and one registered read port.
module tods_store #(
    parameter int NUM_SCHEDULES = tods_pkg::NUM_SCHEDULES_DEF
) (
    input  logic                                                  i_clk,
    input  tods_pkg::t_store_wr                                   i_wr,
    input  logic [((NUM_SCHEDULES > 1) ? $clog2(NUM_SCHEDULES) : 1)-1:0] i_wr_addr,
    input  tods_pkg::t_entry                                      i_wr_entry,
    input  logic [((NUM_SCHEDULES > 1) ? $clog2(NUM_SCHEDULES) : 1)-1:0] i_rd_addr,
    output tods_pkg::t_entry                                      o_rd_entry,
    output logic                                                  o_rd_armed
);
    import tods_pkg::*;

    t_entry r_entry_mem [NUM_SCHEDULES];
    logic   r_armed_mem [NUM_SCHEDULES];

    // Write entries on append
    always_ff @(posedge i_clk) begin
        if (i_wr.entry_we) begin
            r_entry_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    // Write armed flags on append and during the table walk
    always_ff @(posedge i_clk) begin
        if (i_wr.armed_we) begin
            r_armed_mem[i_wr_addr] <= i_wr.armed_val;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        o_rd_entry <= r_entry_mem[i_rd_addr];
        o_rd_armed <= r_armed_mem[i_rd_addr];
    end

endmodule

@@ hdl/time_of_day_schedule_trigger.sv @@
// Time-of-day schedule trigger: entry table, tick sequencer and event output.
//
// Input channel (i_valid / o_stall / i_item) carries ticks, appends and clears.
// Output channel (o_valid / i_stall / o_item) carries start and stop events.
// An append or clear leaves the sequencer idle, so the block stays ready.
// A tick with N table entries walks the table one entry per cycle while the
// event registers have room, through the single entry-store read port and
// one compare unit, then releases the held final event from a flush state.
// Each event of a tick passes the holding register and then the output
// register; the final one is marked with last. A tick with an empty table
// gives no event and leaves the block idle.
// Events pass through a one-deep holding register and an output register, so
// a stalled receiver stops the walk only when both are full; nothing is lost.
// A new item is taken while the final event still waits on the output.
// Reset empties the table, forgets the previous tick and clears both event
// registers; the entry store itself needs no clearing.
module time_of_day_schedule_trigger #(
    parameter int NUM_SCHEDULES = tods_pkg::NUM_SCHEDULES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tods_pkg::t_in_item i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output tods_pkg::t_out_item o_item
);
    import tods_pkg::*;

    localparam int IW = (NUM_SCHEDULES > 1) ? $clog2(NUM_SCHEDULES) : 1;
    localparam int CW = $clog2(NUM_SCHEDULES + 1);
    localparam logic [CW-1:0] NUM_C = CW'(NUM_SCHEDULES);
    localparam logic [EVT_CNT_W-1:0] MAX_EVT_C = EVT_CNT_W'(MAX_EVENTS);

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count;
    logic [SEC_W-1:0]      r_last_sec;
    logic                  r_last_valid;
    logic [SEC_W-1:0]      r_now;
    logic [SEC_W-1:0]      r_since;
    logic [6:0]            r_day_bit;
    logic [IW-1:0]         r_idx;
    logic [EVT_CNT_W-1:0]  r_evt_cnt;
    logic                  r_pend_valid;
    t_out_item             r_pend;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  in_xfer, tick_go, append_go, clear_go, out_free;
    logic [SEC_W-1:0]      since_c;
    logic [6:0]            day_bit_c;
    logic [CW-1:0]         idx_inc;
    logic                  walk_end;
    logic [IW+IDX_OUT_W-1:0] idx_ext;

    t_store_wr             st_wr;
    logic [IW-1:0]         wr_addr, rd_addr;
    t_entry                wr_entry, rd_entry;
    logic                  rd_armed;

    logic                  stop_hit, before_start, day_block, start_hit;
    logic                  evt_hit, evt_keep, armed_next;
    t_out_item             new_evt;
    logic                  commit, flush_go, out_load;

    tods_store #(.NUM_SCHEDULES(NUM_SCHEDULES)) u_store (
        .i_clk      (i_clk),
        .i_wr       (st_wr),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry),
        .o_rd_armed (rd_armed)
    );

    // Decode the input transfer
    assign in_xfer   = i_valid && (r_state == ST_IDLE);
    assign tick_go   = in_xfer && (i_item.opcode == OP_TICK) && (r_count != '0);
    assign append_go = in_xfer && (i_item.opcode == OP_APPEND)
                       && (i_item.entry_function != FUNC_NONE) && (r_count < NUM_C);
    assign clear_go  = in_xfer && (i_item.opcode == OP_CLEAR);
    assign out_free  = !r_out_valid || !i_stall;

    assign wr_entry.start      = i_item.entry_start;
    assign wr_entry.has_stop   = i_item.entry_has_stop;
    assign wr_entry.stop       = i_item.entry_stop;
    assign wr_entry.week_flags = i_item.entry_week_flags;
    assign wr_entry.func       = i_item.entry_function;

    // Form the catch-up window and the weekday bit of a tick
    always_comb begin
        since_c = (r_last_valid && (r_last_sec < i_item.second_of_day))
                  ? r_last_sec + 1'b1 : i_item.second_of_day;
        day_bit_c = '0;
        if (i_item.day_of_week != 3'd0) begin
            day_bit_c = 7'b1 << (i_item.day_of_week - 3'd1);
        end
    end

    // Walk position
    assign idx_inc  = CW'(r_idx) + 1'b1;
    assign walk_end = (idx_inc == r_count);
    assign idx_ext  = {{IDX_OUT_W{1'b0}}, r_idx};

    // Evaluate the entry read from the store
    always_comb begin
        stop_hit     = rd_entry.has_stop && (rd_entry.stop >= r_since)
                       && (rd_entry.stop <= r_now);
        before_start = r_now < rd_entry.start;
        day_block    = (rd_entry.week_flags[6:0] != '0)
                       && ((rd_entry.week_flags[6:0] & r_day_bit) == '0);
        start_hit    = !stop_hit && !before_start && !day_block && rd_armed
                       && (rd_entry.start >= r_since) && (rd_entry.start <= r_now);
        evt_hit      = stop_hit || start_hit;
        evt_keep     = evt_hit && (r_evt_cnt < MAX_EVT_C);

        if (stop_hit) begin
            armed_next = rd_armed;
        end else if (before_start) begin
            armed_next = 1'b1;
        end else if (start_hit) begin
            armed_next = rd_entry.week_flags[REPEAT_BIT];
        end else begin
            armed_next = rd_armed;
        end

        new_evt.action      = stop_hit ? ACT_STOP : ACT_START;
        new_evt.function_id = rd_entry.func;
        new_evt.entry_index = idx_ext[IDX_OUT_W-1:0];
        new_evt.last        = 1'b0;
    end

    // Sequencer outputs
    always_comb begin
        st_wr    = '0;
        wr_addr  = IW'(r_count);
        rd_addr  = '0;
        commit   = 1'b0;
        flush_go = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                st_wr.entry_we  = append_go;
                st_wr.armed_we  = append_go;
                st_wr.armed_val = 1'b1;
            end
            ST_EVAL: begin
                // Hold the entry while it has an event to keep and both event registers are full
                commit          = !(evt_keep && r_pend_valid && !out_free);
                wr_addr         = r_idx;
                st_wr.armed_we  = commit;
                st_wr.armed_val = armed_next;
                rd_addr         = commit ? IW'(idx_inc) : r_idx;
            end
            ST_FLUSH: begin
                flush_go = r_pend_valid && out_free;
            end
            default: begin
            end
        endcase
    end

    assign out_load = (commit && evt_keep && r_pend_valid) || flush_go;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (tick_go) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (commit && walk_end) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_last_sec   <= '0;
            r_last_valid <= 1'b0;
            r_idx        <= '0;
            r_evt_cnt    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (append_go) begin
                r_count <= r_count + 1'b1;
            end else if (clear_go) begin
                r_count <= '0;
            end

            if (tick_go) begin
                r_last_sec   <= i_item.second_of_day;
                r_last_valid <= 1'b1;
                r_idx        <= '0;
                r_evt_cnt    <= '0;
            end else if (commit) begin
                r_idx <= IW'(idx_inc);
                if (evt_keep) begin
                    r_evt_cnt <= r_evt_cnt + 1'b1;
                end
            end

            if (commit && evt_keep) begin
                r_pend_valid <= 1'b1;
            end else if (flush_go) begin
                r_pend_valid <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_now     <= i_item.second_of_day;
            r_since   <= since_c;
            r_day_bit <= day_bit_c;
        end
        if (commit && evt_keep) begin
            r_pend <= new_evt;
        end
        // Mark the event released from the flush state as the final one
        if (out_load) begin
            r_out <= '{action:      r_pend.action,
                       function_id: r_pend.function_id,
                       entry_index: r_pend.entry_index,
                       last:        flush_go};
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

@@ hdl/tods_checker.sv @@
// Port-level checker for the schedule trigger and its bind.
`include "time_of_day_schedule_trigger_assert.svh"

module tods_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input tods_pkg::t_in_item  i_item,
    input logic                o_valid,
    input logic                i_stall,
    input tods_pkg::t_out_item o_item
);
    import tods_pkg::*;

    // Hold a stalled event
    `TODS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_item), "stalled event changed")

    // Idle block with an empty output never produces an event in the next cycle
    `TODS_ASSERT_NEXT(a_idle_no_event, i_clk, i_rst_n, !o_stall && !o_valid, !o_valid, "event appeared from idle")

    // A non-final event is shown only while the tick is still being worked
    `TODS_ASSERT_SAME(a_nonlast_busy, i_clk, i_rst_n, o_valid && !o_item.last, o_stall, "non-final event while idle")

    // Append, clear and unused opcodes leave the block ready
    `TODS_ASSERT_NEXT(a_nontick_ready, i_clk, i_rst_n, i_valid && !o_stall && (i_item.opcode != OP_TICK), !o_stall, "busy after non-tick transfer")

endmodule

bind time_of_day_schedule_trigger tods_checker u_checker (.*);
